FILE: sv/srle_pkg.sv
// ---------------------------------------------------------------------------
// srle_pkg: shared types and constants
// Decode phases, controller states, datapath actions, register indexes and
// the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package srle_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR = 2'd3;

    // coding formats
    localparam logic [1:0] FMT_NIBBLE = 2'd0;
    localparam logic [1:0] FMT_SHORT  = 2'd1;
    localparam logic [1:0] FMT_OPCODE = 2'd2;

    // opcodes of the 256-colour format, bits 7..6
    localparam logic [1:0] OP_COPY   = 2'b00;
    localparam logic [1:0] OP_IGNORE = 2'b01;
    localparam logic [1:0] OP_FILL   = 2'b10;
    localparam logic [1:0] OP_SKIP   = 2'b11;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_FILL,
        PH_LIT
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RUN,
        ST_SKIP
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_SKIP
    } action_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic write_px;
        logic skip_px;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    last;
        logic    out_free;
        logic    cfg_busy;
    } stat_t;

endpackage

FILE: sv/srle_ifs.sv
// ---------------------------------------------------------------------------
// srle channel interfaces
// Valid/ready channels for coded bytes and for pixel writes.
// ---------------------------------------------------------------------------
interface srle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_cel;

    modport source (output valid, output data_byte, output first_of_cel, input ready);
    modport sink   (input valid, input data_byte, input first_of_cel, output ready);
endinterface

interface srle_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_index;
    logic [7:0]  color;
    logic        last_of_run;
    logic        cel_complete;

    modport source (output valid, output pixel_index, output color, output last_of_run,
                    output cel_complete, input ready);
    modport sink   (input valid, input pixel_index, input color, input last_of_run,
                    input cel_complete, output ready);
endinterface

FILE: sv/srle_ctrl.sv
// ---------------------------------------------------------------------------
// srle_ctrl: decoder sequencer
// Accepts a byte, has it decoded, then steps the datapath through its
// write or skip run one pixel per cycle; writes wait on a stalled output.
// ---------------------------------------------------------------------------
module srle_ctrl
    import srle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !stat.cfg_busy;
                if (in_valid && !stat.cfg_busy)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                case (stat.action)
                    ACT_WRITE: state_next = ST_RUN;
                    ACT_SKIP:  state_next = ST_SKIP;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_RUN:
            begin
                // hold while the output beat is still waiting
                if (stat.out_free)
                begin
                    cmd.write_px = 1'b1;
                    if (stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SKIP:
            begin
                cmd.skip_px = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/srle_datapath.sv
// ---------------------------------------------------------------------------
// srle_datapath: decoder state, position tracking and output register
// Holds configuration, cel position and run state; decodes the captured
// byte and produces one pixel write or skip per step command.
// ---------------------------------------------------------------------------
module srle_datapath
    import srle_pkg::*;
#(
    parameter int MAX_PIXELS = 64000
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            data_byte,
    input  logic                  first_of_cel,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    srle_pixel_if.source          pixels
);

    logic [1:0]  format_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic        mirror_reg;
    logic [15:0] total_reg;
    logic        cfg_wait_reg;

    phase_t      phase_reg;
    logic [5:0]  run_left_reg;
    logic [15:0] column_reg;
    logic [15:0] row_base_reg;
    logic [15:0] pixels_done_reg;
    logic        finished_reg;

    logic [7:0]  byte_reg;
    logic [5:0]  cnt_reg;
    logic [7:0]  color_reg;

    logic        out_valid_reg;
    logic [15:0] out_index_reg;
    logic [7:0]  out_color_reg;
    logic        out_last_reg;
    logic        out_complete_reg;

    logic [31:0] area;
    logic [15:0] total_next;

    logic        fin_now;
    action_t     dec_action;
    logic [5:0]  dec_cnt;
    logic [7:0]  dec_color;
    phase_t      dec_phase;
    logic [5:0]  dec_run_left;

    logic [15:0] pd_inc;
    logic [15:0] col_inc;
    logic        col_wrap;
    logic        fin_after;
    logic [15:0] col_map;
    logic [15:0] pix_addr;
    logic        step;

    // pixel count, saturated; registered, so it lags width and height changes
    assign area       = 32'(width_reg) * 32'(height_reg);
    assign total_next = (area > 32'(MAX_PIXELS)) ? 16'(MAX_PIXELS) : area[15:0];

    assign fin_now = finished_reg || (pixels_done_reg >= total_reg);

    always_comb
    begin
        dec_action   = ACT_NONE;
        dec_cnt      = '0;
        dec_color    = byte_reg;
        dec_phase    = phase_reg;
        dec_run_left = run_left_reg;
        case (phase_reg)
            PH_FILL:
            begin
                dec_cnt      = run_left_reg;
                dec_color    = byte_reg;
                dec_action   = (run_left_reg != '0) ? ACT_WRITE : ACT_NONE;
                dec_run_left = '0;
                dec_phase    = PH_CTRL;
            end
            PH_LIT:
            begin
                dec_cnt      = 6'd1;
                dec_color    = byte_reg;
                dec_action   = ACT_WRITE;
                dec_run_left = run_left_reg - 6'd1;
                if (run_left_reg == 6'd1)
                begin
                    dec_phase = PH_CTRL;
                end
            end
            default:
            begin
                case (format_reg)
                    FMT_NIBBLE:
                    begin
                        dec_cnt    = {2'b00, byte_reg[7:4]};
                        dec_color  = {4'h0, byte_reg[3:0]};
                        dec_action = (byte_reg[7:4] != '0) ? ACT_WRITE : ACT_NONE;
                    end
                    FMT_SHORT:
                    begin
                        if (byte_reg[2:0] != '0)
                        begin
                            dec_cnt    = {3'b000, byte_reg[2:0]};
                            dec_color  = {3'b000, byte_reg[7:3]};
                            dec_action = ACT_WRITE;
                        end
                        else
                        begin
                            dec_cnt    = {1'b0, byte_reg[7:3]};
                            dec_action = (byte_reg[7:3] != '0) ? ACT_SKIP : ACT_NONE;
                        end
                    end
                    default:
                    begin
                        case (byte_reg[7:6])
                            OP_COPY:
                            begin
                                if (byte_reg[5:0] != '0)
                                begin
                                    dec_run_left = byte_reg[5:0];
                                    dec_phase    = PH_LIT;
                                end
                            end
                            OP_FILL:
                            begin
                                dec_run_left = byte_reg[5:0];
                                dec_phase    = PH_FILL;
                            end
                            OP_SKIP:
                            begin
                                dec_cnt    = byte_reg[5:0];
                                dec_action = (byte_reg[5:0] != '0) ? ACT_SKIP : ACT_NONE;
                            end
                            OP_IGNORE:
                            begin
                                dec_action = ACT_NONE;
                            end
                            default:
                            begin
                                dec_action = ACT_NONE;
                            end
                        endcase
                    end
                endcase
            end
        endcase
        // a finished cel drops the byte
        if (fin_now)
        begin
            dec_action = ACT_NONE;
        end
    end

    assign pd_inc    = pixels_done_reg + 16'd1;
    assign col_inc   = column_reg + 16'd1;
    assign col_wrap  = (col_inc >= width_reg);
    assign fin_after = (pd_inc >= total_reg);
    assign col_map   = mirror_reg ? (width_reg - 16'd1 - column_reg) : column_reg;
    assign pix_addr  = row_base_reg + col_map;
    assign step      = cmd.write_px || cmd.skip_px;

    assign stat.action   = dec_action;
    assign stat.last     = (cnt_reg == 6'd1) || fin_after;
    assign stat.out_free = !out_valid_reg || pixels.ready;
    assign stat.cfg_busy = cfg_we || cfg_wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg      <= FMT_OPCODE;
            width_reg       <= '0;
            height_reg      <= '0;
            mirror_reg      <= 1'b0;
            total_reg       <= '0;
            cfg_wait_reg    <= 1'b0;
            phase_reg       <= PH_CTRL;
            run_left_reg    <= '0;
            column_reg      <= '0;
            row_base_reg    <= '0;
            pixels_done_reg <= '0;
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            total_reg    <= total_next;
            cfg_wait_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FORMAT: format_reg <= cfg_data[1:0];
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_MIRROR: mirror_reg <= cfg_data[0];
                    default:    format_reg <= format_reg;
                endcase
            end

            if (cmd.capture && first_of_cel)
            begin
                phase_reg       <= PH_CTRL;
                run_left_reg    <= '0;
                column_reg      <= '0;
                row_base_reg    <= '0;
                pixels_done_reg <= '0;
                finished_reg    <= 1'b0;
            end

            if (cmd.decode)
            begin
                if (fin_now)
                begin
                    finished_reg <= 1'b1;
                end
                else
                begin
                    phase_reg    <= dec_phase;
                    run_left_reg <= dec_run_left;
                end
            end

            if (step)
            begin
                pixels_done_reg <= pd_inc;
                if (col_wrap)
                begin
                    column_reg   <= '0;
                    row_base_reg <= row_base_reg + width_reg;
                end
                else
                begin
                    column_reg <= col_inc;
                end
                if (fin_after)
                begin
                    finished_reg <= 1'b1;
                end
            end

            if (cmd.write_px)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixels.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= data_byte;
        end
        if (cmd.decode)
        begin
            cnt_reg   <= dec_cnt;
            color_reg <= dec_color;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
        if (cmd.write_px)
        begin
            out_index_reg    <= pix_addr;
            out_color_reg    <= color_reg;
            out_last_reg     <= stat.last;
            out_complete_reg <= fin_after;
        end
    end

    assign pixels.valid        = out_valid_reg;
    assign pixels.pixel_index  = out_index_reg;
    assign pixels.color        = out_color_reg;
    assign pixels.last_of_run  = out_last_reg;
    assign pixels.cel_complete = out_complete_reg;

endmodule

FILE: sv/sprite_rle_cel_decoder.sv
// ---------------------------------------------------------------------------
// sprite_rle_cel_decoder: run-length sprite cel decoder
// Turns run-length coded sprite bytes into pixel writes addressed within
// the cel, in 16-, 32- and 256-colour formats.
// ---------------------------------------------------------------------------
//
//  channel   role   beat
//  -------   ----   -----------------------------------------------
//  coded     sink   data_byte, first_of_cel
//  pixels    source pixel_index, color, last_of_run, cel_complete
//  cfg_*     write  cfg_we, cfg_index, cfg_data (no handshake)
//
//  A byte is accepted, then decoded, then its run (0 to 63 written or skipped
//  pixels) is stepped one pixel per cycle, writes only while the output is free.
//  A stalled pixels sink holds a write run; a new byte is accepted while the
//  last write still waits. coded.ready drops for the cycle of a
//  configuration write and the cycle after it. Reset is asynchronous,
//  active low, and needs no clearing pass.
//
module sprite_rle_cel_decoder
    import srle_pkg::*;
#(
    parameter int MAX_PIXELS = 64000
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    srle_byte_if.sink             coded,
    srle_pixel_if.source          pixels
);

    cmd_t  cmd;
    stat_t stat;

    srle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (coded.valid),
        .in_ready (coded.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srle_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (coded.data_byte),
        .first_of_cel (coded.first_of_cel),
        .cmd          (cmd),
        .stat         (stat),
        .pixels       (pixels)
    );

    // an accepted beat is decoded in the next cycle
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (coded.valid && coded.ready) |=> cmd.decode)
        else $error("accepted byte was not decoded next cycle");

    // no new byte while one is being decoded or its run is in progress
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decode || cmd.write_px || cmd.skip_px) |-> !coded.ready)
        else $error("byte accepted while a run is in progress");

    // the write that completes the cel ends its byte's run
    a_complete_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.cel_complete) |-> pixels.last_of_run)
        else $error("cel completion write not marked last of run");

    // a pixel write never overruns a beat still waiting at the output
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && !pixels.ready) |-> !cmd.write_px)
        else $error("pixel write issued over a stalled output beat");

endmodule

FILE: tb/tb_sprite_rle_cel_decoder.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sprite_rle_cel_decoder: self-checking bench for the sprite cel decoder
// Walks a short table of coded bytes and register writes covering each
// format, the opcodes, empty and overrun cels and mirrored addressing, then
// streams random cels, some cut short, under random register settings. Every
// pixel write is checked against a local decoder model or a table row, with
// random gaps on the byte side and random stalls on the pixel side.
// ---------------------------------------------------------------------------
module tb_sprite_rle_cel_decoder;
    import srle_pkg::*;

    localparam int          MAX_PIXELS   = 64000;
    localparam int          MAX_WRITES   = 63;
    localparam int          RANDOM_ITEMS = 86;
    localparam int          SETTLE_CYC   = 70;
    localparam int          WATCHDOG_CYC = 3000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [1:0]  FMT_ALIAS    = 2'd3;   // unused code, decodes as opcode format

    typedef struct packed {
        logic [15:0] pixel_index;
        logic [7:0]  color;
        logic        last_of_run;
        logic        cel_complete;
    } pixel_write_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PRED,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [15:0] value;
        logic        first;
        logic        n_exp;
        logic [15:0] px;
        logic [7:0]  col;
        logic        done;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    srle_byte_if  coded_ch ();
    srle_pixel_if pixel_ch ();

    sprite_rle_cel_decoder #(.MAX_PIXELS(MAX_PIXELS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coded     (coded_ch),
        .pixels    (pixel_ch)
    );

    // decoder model: register copies and walk state
    logic [1:0]  reg_format;
    logic [15:0] reg_width;
    logic [15:0] reg_height;
    logic        reg_mirror;
    phase_t      pr_phase;
    logic [5:0]  pr_run;
    logic [15:0] pr_col;
    logic [15:0] pr_row_base;
    logic [15:0] pr_done;
    logic        pr_finished;

    pixel_write_t pending_writes [$];
    pixel_write_t step_writes [$];

    int err_count = 0;
    int idle_cycles = 0;
    bit sender_calm;

    stim_row_t dir_rows [$] = '{
        // reset registers: empty cel, byte ignored
        '{ROW_TYPED, REG_FORMAT, 16'h0085, 1'b1, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_CFG,   REG_WIDTH,  16'd4,    1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_CFG,   REG_HEIGHT, 16'd2,    1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_CFG,   REG_MIRROR, 16'd0,    1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h0001, 1'b1, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h00FF, 1'b0, 1'b1, 16'd0,     8'hFF, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h0083, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_PRED,  REG_FORMAT, 16'h0000, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h0041, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h00C2, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        // fill of length zero still eats its colour byte
        '{ROW_TYPED, REG_FORMAT, 16'h0080, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h0055, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        // copy run longer than the cel: stops at the last pixel
        '{ROW_TYPED, REG_FORMAT, 16'h003F, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h00AA, 1'b0, 1'b1, 16'd6,     8'hAA, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h0012, 1'b0, 1'b1, 16'd7,     8'h12, 1'b1},
        '{ROW_TYPED, REG_FORMAT, 16'h009F, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_CFG,   REG_FORMAT, 16'(FMT_NIBBLE), 1'b0, 1'b0, 16'd0, 8'h00, 1'b0},
        '{ROW_CFG,   REG_MIRROR, 16'd1,    1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_CFG,   REG_WIDTH,  16'd5,    1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_CFG,   REG_HEIGHT, 16'd3,    1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_PRED,  REG_FORMAT, 16'h00F7, 1'b1, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h000C, 1'b1, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h001A, 1'b0, 1'b1, 16'd4,     8'h0A, 1'b0},
        '{ROW_CFG,   REG_FORMAT, 16'(FMT_SHORT), 1'b0, 1'b0, 16'd0, 8'h00, 1'b0},
        '{ROW_CFG,   REG_MIRROR, 16'd0,    1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_CFG,   REG_WIDTH,  16'd64000, 1'b0, 1'b0, 16'd0,    8'h00, 1'b0},
        '{ROW_CFG,   REG_HEIGHT, 16'd64000, 1'b0, 1'b0, 16'd0,    8'h00, 1'b0},
        '{ROW_PRED,  REG_FORMAT, 16'h00FF, 1'b1, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h00F8, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h0001, 1'b0, 1'b1, 16'd38,    8'h00, 1'b0},
        '{ROW_CFG,   REG_FORMAT, 16'(FMT_ALIAS), 1'b0, 1'b0, 16'd0, 8'h00, 1'b0},
        '{ROW_CFG,   REG_WIDTH,  16'd64000, 1'b0, 1'b0, 16'd0,    8'h00, 1'b0},
        '{ROW_CFG,   REG_HEIGHT, 16'd1,    1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_CFG,   REG_MIRROR, 16'd1,    1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h0081, 1'b1, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h005C, 1'b0, 1'b1, 16'd63999, 8'h5C, 1'b0},
        // format switch while literals are pending: bytes stay literals
        '{ROW_TYPED, REG_FORMAT, 16'h0002, 1'b0, 1'b0, 16'd0,     8'h00, 1'b0},
        '{ROW_CFG,   REG_FORMAT, 16'(FMT_NIBBLE), 1'b0, 1'b0, 16'd0, 8'h00, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h0033, 1'b0, 1'b1, 16'd63998, 8'h33, 1'b0},
        '{ROW_TYPED, REG_FORMAT, 16'h0044, 1'b0, 1'b1, 16'd63997, 8'h44, 1'b0}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned cel_pixel_total();
        int unsigned t;
        t = 32'(reg_width) * 32'(reg_height);
        if (t > MAX_PIXELS)
            t = MAX_PIXELS;
        return t;
    endfunction

    function automatic void step_position(input int unsigned total);
        pr_done = pr_done + 16'd1;
        pr_col  = pr_col + 16'd1;
        if (pr_col >= reg_width)
        begin
            pr_col      = '0;
            pr_row_base = pr_row_base + reg_width;
        end
        if (pr_done >= total)
            pr_finished = 1'b1;
    endfunction

    function automatic void paint_pixel(input logic [7:0] color, input int unsigned total);
        pixel_write_t w;
        logic [15:0]  c;
        c = reg_mirror ? reg_width - 16'd1 - pr_col : pr_col;
        w.pixel_index = pr_row_base + c;
        w.color       = color;
        w.last_of_run = 1'b0;
        step_position(total);
        w.cel_complete = pr_finished;
        step_writes.push_back(w);
    endfunction

    function automatic void paint_run(input int unsigned run, input logic [7:0] color,
                                      input int unsigned total);
        while (run > 0 && !pr_finished && step_writes.size() < MAX_WRITES)
        begin
            paint_pixel(color, total);
            run--;
        end
    endfunction

    function automatic void skip_pixels(input int unsigned run, input int unsigned total);
        while (run > 0 && !pr_finished)
        begin
            step_position(total);
            run--;
        end
    endfunction

    function automatic void reset_walk();
        pr_phase    = PH_CTRL;
        pr_run      = '0;
        pr_col      = '0;
        pr_row_base = '0;
        pr_done     = '0;
        pr_finished = 1'b0;
    endfunction

    // decode one coded byte into step_writes; returns 1 when the byte is dropped
    function automatic bit decode_byte(input logic [7:0] b, input logic first);
        int unsigned  total;
        pixel_write_t w;
        step_writes.delete();
        total = cel_pixel_total();
        if (first)
            reset_walk();
        if (pr_done >= total)
            pr_finished = 1'b1;
        if (pr_finished)
            return 1'b1;
        if (pr_phase == PH_FILL)
        begin
            paint_run(pr_run, b, total);
            pr_run   = '0;
            pr_phase = PH_CTRL;
        end
        else if (pr_phase == PH_LIT)
        begin
            paint_pixel(b, total);
            pr_run = pr_run - 6'd1;
            if (pr_run == 0 || pr_finished)
            begin
                pr_run   = '0;
                pr_phase = PH_CTRL;
            end
        end
        else if (reg_format == FMT_NIBBLE)
            paint_run(b[7:4], {4'h0, b[3:0]}, total);
        else if (reg_format == FMT_SHORT)
        begin
            if (b[2:0] != 3'd0)
                paint_run(b[2:0], {3'b000, b[7:3]}, total);
            else
                skip_pixels(b[7:3], total);
        end
        else
        begin
            case (b[7:6])
                OP_COPY:
                begin
                    if (b[5:0] != 6'd0)
                    begin
                        pr_run   = b[5:0];
                        pr_phase = PH_LIT;
                    end
                end
                OP_FILL:
                begin
                    pr_run   = b[5:0];
                    pr_phase = PH_FILL;
                end
                OP_SKIP:   skip_pixels(b[5:0], total);
                default:   ;
            endcase
        end
        if (step_writes.size() > 0)
        begin
            w = step_writes.pop_back();
            w.last_of_run = 1'b1;
            step_writes.push_back(w);
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        if (sender_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic accept_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            coded_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        coded_ch.valid        <= 1'b1;
        coded_ch.data_byte    <= b;
        coded_ch.first_of_cel <= first;
        do
            @(posedge clk);
        while (!coded_ch.ready);
    endtask

    task automatic send_coded(input logic [7:0] b, input logic first, output bit dropped);
        accept_byte(b, first);
        dropped = decode_byte(b, first);
        foreach (step_writes[i])
            pending_writes.push_back(step_writes[i]);
    endtask

    // hold the byte side until every write is back and any skip has run out
    task automatic settle();
        @(negedge clk);
        coded_ch.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_FORMAT: reg_format = value[1:0];
            REG_WIDTH:  reg_width  = value;
            REG_HEIGHT: reg_height = value;
            default:    reg_mirror = value[0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic walk_directed();
        stim_row_t    row;
        pixel_write_t w;
        bit           dropped;
        bit           prev_cfg;
        prev_cfg = 1'b1;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                if (!prev_cfg)
                    settle();
                cfg_write(row.idx, row.value);
                prev_cfg = 1'b1;
            end
            else if (row.kind == ROW_PRED)
            begin
                send_coded(row.value[7:0], row.first, dropped);
                prev_cfg = 1'b0;
            end
            else
            begin
                // advance the model, but hold the DUT to the hand-written write
                accept_byte(row.value[7:0], row.first);
                dropped = decode_byte(row.value[7:0], row.first);
                if (row.n_exp)
                begin
                    w.pixel_index  = row.px;
                    w.color        = row.col;
                    w.last_of_run  = 1'b1;
                    w.cel_complete = row.done;
                    pending_writes.push_back(w);
                end
                prev_cfg = 1'b0;
            end
        end
    endtask

    task automatic randomize_config();
        int          r;
        logic [15:0] w;
        logic [15:0] h;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            w = 16'($urandom_range(1, 10));
            h = 16'($urandom_range(1, 6));
        end
        else if (r < 85)
        begin
            w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 8));
            h = (w == 16'd0) ? 16'($urandom_range(0, 8)) : 16'd0;
        end
        else if (r < 93)
        begin
            w = 16'd64000;
            h = 16'($urandom_range(1, 64000));
        end
        else
        begin
            w = 16'($urandom_range(1, 64000));
            h = 16'($urandom_range(1, 3));
        end
        cfg_write(REG_FORMAT, 16'($urandom_range(0, 3)));
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_MIRROR, 16'($urandom_range(0, 1)));
    endtask

    // one unit of coded bytes for the current format and phase, not always complete
    task automatic build_burst(ref logic [7:0] burst [$]);
        int         r;
        int         run;
        logic [7:0] b;
        burst.delete();
        b = 8'($urandom);
        r = $urandom_range(0, 99);
        if (reg_format == FMT_NIBBLE)
            burst.push_back(b);
        else if (reg_format == FMT_SHORT)
        begin
            if (r < 25)
                b[2:0] = 3'd0;
            burst.push_back(b);
        end
        else if (pr_phase != PH_CTRL || r < 10)
            burst.push_back(b);
        else if (r < 45)
        begin
            run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 63);
            burst.push_back({OP_COPY, 6'(run)});
            repeat (run) burst.push_back(8'($urandom));
            // cut the literals short now and then
            if (run > 1 && $urandom_range(0, 9) == 0)
                void'(burst.pop_back());
        end
        else if (r < 80)
        begin
            r = $urandom_range(0, 99);
            run = (r < 15) ? 0 : (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 63);
            burst.push_back({OP_FILL, 6'(run)});
            if ($urandom_range(0, 19) != 0)
                burst.push_back(8'($urandom));
        end
        else if (r < 95)
            burst.push_back({OP_SKIP, 6'($urandom_range(0, 63))});
        else
            burst.push_back({OP_IGNORE, 6'($urandom)});
    endtask

    task automatic run_random_cels();
        logic [7:0] burst [$];
        int         sent;
        int         cel_goal;
        int         cel_useful;
        int         cel_sent;
        bit         first_due;
        bit         dropped;
        logic       first;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            randomize_config();
            sender_calm = ($urandom_range(0, 3) == 0);
            cel_goal    = $urandom_range(8, 20);
            cel_useful  = 0;
            cel_sent    = 0;
            first_due   = ($urandom_range(0, 99) < 85);
            while (cel_useful < cel_goal && cel_sent < 3 * cel_goal
                   && sent + cel_sent < RANDOM_ITEMS)
            begin
                build_burst(burst);
                foreach (burst[i])
                begin
                    first = first_due || ($urandom_range(0, 39) == 0);
                    first_due = 1'b0;
                    send_coded(burst[i], first, dropped);
                    cel_sent++;
                    if (!dropped)
                        cel_useful++;
                end
            end
            sent += cel_sent;
        end
    endtask

    // pixel sink: random short and long stalls, with calm stretches
    initial
    begin
        int stall_left;
        int cyc;
        bit sink_calm;
        pixel_ch.ready = 1'b0;
        stall_left = 0;
        cyc = 0;
        sink_calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 300 == 0)
                sink_calm = ($urandom_range(0, 2) == 0);
            if (stall_left > 0)
            begin
                pixel_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pixel_ch.ready <= 1'b1;
                if (!sink_calm)
                begin
                    if ($urandom_range(0, 99) < 10)
                        stall_left = $urandom_range(1, 3);
                    else if ($urandom_range(0, 99) < 2)
                        stall_left = $urandom_range(12, 40);
                end
            end
        end
    end

    // write checker: oldest expectation first
    always @(posedge clk)
    begin
        pixel_write_t got;
        pixel_write_t want;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            got.pixel_index  = pixel_ch.pixel_index;
            got.color        = pixel_ch.color;
            got.last_of_run  = pixel_ch.last_of_run;
            got.cel_complete = pixel_ch.cel_complete;
            if (pending_writes.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected write: index %0d color %02h last %0b complete %0b",
                             got.pixel_index, got.color, got.last_of_run, got.cel_complete);
            end
            else
            begin
                want = pending_writes.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display({"write mismatch: expected index %0d color %02h last %0b",
                                  " complete %0b, got index %0d color %02h last %0b",
                                  " complete %0b"},
                                 want.pixel_index, want.color, want.last_of_run,
                                 want.cel_complete, got.pixel_index, got.color,
                                 got.last_of_run, got.cel_complete);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (coded_ch.valid && coded_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYC)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_CYC);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        coded_ch.valid        = 1'b0;
        coded_ch.data_byte    = 8'h00;
        coded_ch.first_of_cel = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_FORMAT;
        cfg_data    = '0;
        rst_n       = 1'b0;
        sender_calm = 1'b0;
        reg_format  = FMT_OPCODE;
        reg_width   = '0;
        reg_height  = '0;
        reg_mirror  = 1'b0;
        reset_walk();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        walk_directed();
        run_random_cels();

        settle();
        if (err_count == 0 && pending_writes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
